### sv/tcpq_pkg.sv
// shared constants, types and pointer helpers for the two-class priority queue
package tcpq_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int TDATA_W = ((OP_W + VAL_W + 7) / 8) * 8;

    localparam logic signed [VAL_W-1:0] URGENT_MIN_RST = 32'sd60;

    localparam logic [OP_W-1:0] OP_PLAIN = 2'd0;
    localparam logic [OP_W-1:0] OP_PRIO  = 2'd1;
    localparam logic [OP_W-1:0] OP_DEQ   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic            latch_in;
        logic            rd_head;
        logic            rd_scan;
        logic            wr_tail;
        logic            wr_shift;
        logic            wr_ins;
        logic            head_inc;
        logic            head_dec;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            scan_clr;
        logic            scan_inc;
        logic            res_load;
        logic [ST_W-1:0] res_status;
        logic            res_take;
        logic            out_load;
    } tcpq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            in_urgent;
        logic            scan_end;
        logic            data_urgent;
    } tcpq_sts_t;

    // circular pointer plus offset, offset at most DEPTH
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                              input logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - AW){1'b0}}, p} + {1'b0, n};
        if (s >= (CNT_W + 1)'(DEPTH))
            s = s - (CNT_W + 1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0)
            r = AW'(DEPTH - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

endpackage

### sv/tcpq_dp.sv
// datapath: entry memory, head pointer, occupancy, scan counter and result registers
module tcpq_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcpq_pkg::tcpq_cmd_t                  cmd,
    output tcpq_pkg::tcpq_sts_t                  sts,
    input  logic [tcpq_pkg::OP_W-1:0]            in_op,
    input  logic signed [tcpq_pkg::VAL_W-1:0]    in_value,
    input  logic                                 cfg_we,
    input  logic signed [tcpq_pkg::VAL_W-1:0]    cfg_wdata,
    output logic [tcpq_pkg::ST_W-1:0]            res_status,
    output logic signed [tcpq_pkg::VAL_W-1:0]    res_value
);
    import tcpq_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    logic [AW-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic signed [VAL_W-1:0] umin_reg;
    logic [OP_W-1:0]         op_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic [ST_W-1:0]         res_status_reg;
    logic signed [VAL_W-1:0] res_value_reg;

    logic [AW-1:0]           scan_addr;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_en;
    logic signed [VAL_W-1:0] wr_data;

    assign scan_addr = ptr_add(head_reg, scan_reg);
    assign rd_addr   = cmd.rd_head ? head_reg : scan_addr;
    assign wr_en     = cmd.wr_tail | cmd.wr_shift | cmd.wr_ins;
    assign wr_addr   = cmd.wr_tail ? ptr_add(head_reg, count_reg) : ptr_dec(scan_addr);
    assign wr_data   = cmd.wr_shift ? rd_data_reg : value_reg;

    // entry store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_head | cmd.rd_scan)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.head_inc)
            head_next = ptr_add(head_reg, CNT_W'(1));
        else if (cmd.head_dec)
            head_next = ptr_dec(head_reg);

        count_next = count_reg;
        if (cmd.cnt_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec)
            count_next = count_reg - 1'b1;

        scan_next = scan_reg;
        if (cmd.scan_clr)
            scan_next = '0;
        else if (cmd.scan_inc)
            scan_next = scan_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            scan_reg  <= '0;
            umin_reg  <= URGENT_MIN_RST;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            if (cfg_we)
                umin_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_take ? rd_data_reg : '0;
        end
    end

    assign sts.op          = op_reg;
    assign sts.full        = (count_reg == CNT_W'(DEPTH));
    assign sts.empty       = (count_reg == '0);
    assign sts.in_urgent   = (value_reg >= umin_reg);
    assign sts.scan_end    = (scan_reg == count_reg);
    assign sts.data_urgent = (rd_data_reg >= umin_reg);

    assign res_status = res_status_reg;
    assign res_value  = res_value_reg;

endmodule

### sv/tcpq_ctrl.sv
// controller: sequences decode, urgent scan-and-shift, dequeue and result hand-off
module tcpq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    input  tcpq_pkg::tcpq_sts_t sts,
    output tcpq_pkg::tcpq_cmd_t cmd
);
    import tcpq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_CHK = 3'd3;
    localparam logic [2:0] S_DEQ_WAIT = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_PLAIN, OP_PRIO:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_FINISH;
                        end
                        else if (sts.op == OP_PRIO && sts.in_urgent)
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                        else
                        begin
                            cmd.wr_tail    = 1'b1;
                            cmd.cnt_inc    = 1'b1;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_DONE;
                            state_next     = S_FINISH;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (sts.empty)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = S_DEQ_WAIT;
                        end
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_DONE;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    cmd.wr_ins     = 1'b1;
                    cmd.head_dec   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_DONE;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (sts.data_urgent)
                begin
                    // move the urgent entry one slot towards the head
                    cmd.wr_shift = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.wr_ins     = 1'b1;
                    cmd.head_dec   = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_DONE;
                    state_next     = S_FINISH;
                end
            end
            S_DEQ_WAIT:
            begin
                cmd.head_inc   = 1'b1;
                cmd.cnt_dec    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_take   = 1'b1;
                cmd.res_status = ST_DONE;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### sv/two_class_priority_queue.sv
// top level of the two-class priority queue: controller, datapath and output register
// usage
// - input channel s_*: one item per operation; s_tdata holds operation in bits 1:0
//   (plain enqueue, priority enqueue, dequeue) and the signed value in bits 33:2
// - output channel m_*: exactly one item per input item, in order; m_tdata holds
//   status in bits 1:0 (done, full, empty) and the removed value in bits 33:2
// - cfg_we/cfg_wdata write the signed urgent threshold; write only while idle
// - entries live in a circular store indexed from a head pointer, so a dequeue
//   only moves the head
// - plain enqueue, refusals and the unused code settle in the decode step, a dequeue
//   reads the head first; an urgent priority enqueue reads each entry of the leading
//   urgent run and writes it one slot nearer the head, then inserts the new value
//   behind the run
// - one item is in the block at a time; s_tready is high only when the controller
//   is idle, which it is again from the edge that loads the result into the output
//   register, so the block takes no new item before the last one's result is loaded
// - the result sits in an output register, so the next item is taken while the
//   receiver stalls; a second result waits in the controller until the register frees
// - reset clears the queue to empty and the threshold to 60; no clearing pass
module two_class_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    // operation [1:0], value [33:2], zero padding [39:34]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tcpq_pkg::TDATA_W-1:0]        s_tdata,
    // status [1:0], removed_value [33:2], zero padding [39:34]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tcpq_pkg::TDATA_W-1:0]        m_tdata,
    // urgent threshold write
    input  logic                                cfg_we,
    input  logic signed [tcpq_pkg::VAL_W-1:0]   cfg_wdata
);
    import tcpq_pkg::*;

    tcpq_cmd_t               cmd;
    tcpq_sts_t               sts;
    logic                    out_free;
    logic [ST_W-1:0]         res_status;
    logic signed [VAL_W-1:0] res_value;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]      m_tdata_reg;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcpq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tdata[OP_W-1:0]),
        .in_value   (s_tdata[OP_W+VAL_W-1:OP_W]),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .res_status (res_status),
        .res_value  (res_value)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // result payload, zero padded to whole bytes
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            m_tdata_reg <= {{(TDATA_W - ST_W - VAL_W){1'b0}}, res_value, res_status};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // occupancy can never read as both full and empty
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.full && sts.empty))
        else $error("queue reports full and empty at once");

    // a result is never loaded over one the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // only one item in flight: accept closes the input until the result is out
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // loading a result reopens the input on the next cycle
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> s_tready)
        else $error("input not reopened after result");

endmodule

### tb/tcpq_checker.sv
// result checker for the two-class priority queue: predicts every result and compares it
`timescale 1ns / 100ps
module tcpq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [tcpq_pkg::TDATA_W-1:0]        s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [tcpq_pkg::TDATA_W-1:0]        m_tdata,
    input  logic                                cfg_we,
    input  logic signed [tcpq_pkg::VAL_W-1:0]   cfg_wdata,
    output int                                  error_count,
    output int                                  results_due
);
    import tcpq_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] removed;
    } outcome_t;

    logic signed [VAL_W-1:0] queue_image[$];
    logic signed [VAL_W-1:0] urgent_level;
    outcome_t                outcomes_due[$];

    // one operation applied to the queue image, its outcome queued
    task automatic predict_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        outcome_t res;
        int       pos;
        res.status  = ST_DONE;
        res.removed = '0;
        if (op == OP_PLAIN || op == OP_PRIO)
        begin
            if (queue_image.size() >= DEPTH)
                res.status = ST_FULL;
            else if (op == OP_PRIO && val >= urgent_level)
            begin
                pos = 0;
                while (pos < queue_image.size() && queue_image[pos] >= urgent_level)
                    pos++;
                queue_image.insert(pos, val);
            end
            else
                queue_image.push_back(val);
        end
        else if (op == OP_DEQ)
        begin
            if (queue_image.size() == 0)
                res.status = ST_EMPTY;
            else
                res.removed = queue_image.pop_front();
        end
        outcomes_due.push_back(res);
    endtask

    task automatic check_result(input logic [TDATA_W-1:0] data);
        outcome_t want;
        if (outcomes_due.size() == 0)
        begin
            $error("unexpected item: status %0d, removed_value %0d",
                   data[ST_W-1:0], $signed(data[ST_W+VAL_W-1:ST_W]));
            error_count++;
        end
        else
        begin
            want = outcomes_due.pop_front();
            if (data[ST_W-1:0] !== want.status)
            begin
                $error("status mismatch: expected %0d, actual %0d",
                       want.status, data[ST_W-1:0]);
                error_count++;
            end
            if (data[ST_W+VAL_W-1:ST_W] !== want.removed)
            begin
                $error("removed_value mismatch: expected %0d, actual %0d",
                       want.removed, $signed(data[ST_W+VAL_W-1:ST_W]));
                error_count++;
            end
        end
    endtask

    // results first: an item taken at this edge cannot already have its result out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_image.delete();
            outcomes_due.delete();
            urgent_level = URGENT_MIN_RST;
            error_count  = 0;
            results_due <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (cfg_we)
                urgent_level = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_item(s_tdata[OP_W-1:0], s_tdata[OP_W+VAL_W-1:OP_W]);
            results_due <= outcomes_due.size();
        end
    end

endmodule

### tb/two_class_priority_queue_tb.sv
// top of the two-class priority queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module two_class_priority_queue_tb;
    import tcpq_pkg::*;

    // the one operation code the block must ignore
    localparam logic [OP_W-1:0]        OP_UNUSED     = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'sh7fff_ffff;
    // random items per threshold setting, nine settings in all
    localparam int                     SEGMENT_ITEMS = 83;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    // operation [1:0], value [33:2], zero padding above
    logic [TDATA_W-1:0]        s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    // status [1:0], removed_value [33:2], zero padding above
    logic [TDATA_W-1:0]        m_tdata;
    logic                      cfg_we    = 1'b0;
    logic signed [VAL_W-1:0]   cfg_wdata = '0;

    int                        mismatches;
    int                        results_due;

    // idling odds in percent for each side
    int                        tx_idle_pct = 11;
    int                        rx_idle_pct = 83;

    // stimulus-side copy of the threshold, used only to aim values near it
    logic signed [VAL_W-1:0]   urgent_level = URGENT_MIN_RST;

    // tallies for the closing summary
    int                        n_enq;
    int                        n_deq;
    int                        n_unused;
    int                        n_settings;

    two_class_priority_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tcpq_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .error_count (mismatches),
        .results_due (results_due)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: ready drops at random according to the current idling odds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // generous fixed limit, far beyond the slowest legal run
    initial
    begin
        #(4_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // offer one item, with random idle cycles in front, and wait for it to be taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({val, op});
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_PLAIN || op == OP_PRIO)
            n_enq++;
        else if (op == OP_DEQ)
            n_deq++;
        else
            n_unused++;
    endtask

    // hold off until every result still owed has come back
    // the first edge lets the count catch up with the item just taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // threshold writes only ever land on an idle block
    task automatic set_threshold(input logic signed [VAL_W-1:0] level);
        wait_idle();
        cfg_we       <= 1'b1;
        cfg_wdata    <= level;
        urgent_level  = level;
        n_settings++;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // values cluster round the threshold and the extremes, the rest spread wide
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = urgent_level + VAL_W'($urandom_range(4)) - 2;
            3, 4:
            begin
                case ($urandom_range(3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // nine settings: reset value and one below it, both extremes, around zero and two random ones
    function automatic logic signed [VAL_W-1:0] pick_threshold(input int k);
        logic signed [VAL_W-1:0] level;
        case (k)
            0:       level = URGENT_MIN_RST;
            1:       level = VAL_MIN;
            2:       level = VAL_MAX;
            3:       level = '0;
            4:       level = '1;
            7:       level = 32'sd1;
            8:       level = URGENT_MIN_RST - 1;
            default: level = $urandom();
        endcase
        return level;
    endfunction

    // random traffic in short bursts, each burst leaning towards filling,
    // draining or an even mix so the queue swings between empty and full
    task automatic random_segment(input int n_items);
        int              enq_pct;
        logic [OP_W-1:0] op;
        enq_pct = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 12 == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 20;
                    default: enq_pct = 55;
                endcase
            end
            if ($urandom_range(99) < 2)
                op = OP_UNUSED;
            else if ($urandom_range(99) < enq_pct)
                op = ($urandom_range(99) < 60) ? OP_PRIO : OP_PLAIN;
            else
                op = OP_DEQ;
            send_item(op, pick_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset threshold of 60
        // empty queue: dequeue refused, unused code ignored
        send_item(OP_DEQ, VAL_MAX);
        send_item(OP_UNUSED, VAL_MIN);
        // just below the threshold stays at the tail, even as priority
        send_item(OP_PLAIN, 32'sd59);
        send_item(OP_PRIO, 32'sd59);
        // first urgent value jumps to the head, the next one lines up behind it
        send_item(OP_PRIO, 32'sd60);
        send_item(OP_PRIO, VAL_MAX);
        // plain enqueue of an urgent value still goes to the tail
        send_item(OP_PLAIN, VAL_MAX);
        send_item(OP_PRIO, VAL_MIN);
        send_item(OP_PLAIN, -32'sd1);
        send_item(OP_PRIO, 32'sd0);
        // top up to full, urgent priority values extending the leading run
        for (int k = 0; k < 8; k++)
            send_item((k % 2) ? OP_PRIO : OP_PLAIN, 32'sd100 + k);
        // full queue: both enqueue kinds refused, unused code ignored
        send_item(OP_PLAIN, 32'sd1);
        send_item(OP_PRIO, VAL_MAX);
        send_item(OP_UNUSED, -32'sd1);
        repeat (4) send_item(OP_DEQ, '0);

        // three idling profiles, three threshold settings in each
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 11;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 11;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 3; s++)
            begin
                set_threshold(pick_threshold(ph * 3 + s));
                random_segment(SEGMENT_ITEMS);
            end
        end

        // drain, then allow for the longest urgent insert before the verdict
        wait_idle();
        repeat (2 * DEPTH + 8) @(posedge clk);

        $display("covered %0d enqueues, %0d dequeues and %0d unused-code items",
                 n_enq, n_deq, n_unused);
        $display("over %0d threshold settings and three handshake idling profiles",
                 n_settings);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
